>>> rtl/dqs_pkg.sv
// Shared types, sizes and helpers for the double-ended queue with count and sum.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package dqs_pkg;

    // Ring store size and the widths that follow from it.
    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths of an item and a result.
    localparam int ACT_W   = 3;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    // Action codes of an input item.
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd4;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Operation class decided by the front end.
    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_CLEAR,
        OP_QUERY
    } op_kind_t;

    // A classified item as it waits in the command queue.
    typedef struct packed {
        op_kind_t                  kind;
        logic                      at_front;
        logic signed [DATA_W-1:0]  value;
    } cmd_t;

    // What the back end reports for one item.
    typedef struct packed {
        logic                      done;
        status_t                   status;
        logic [CNT_W-1:0]          count;
        logic signed [DATA_W-1:0]  sum;
    } result_t;

    // Back end sequencer states.
    typedef enum logic {
        B_IDLE,
        B_POP
    } back_state_t;

    // Ring position base + offset, where offset is below DEPTH.
    function automatic logic [ADDR_W-1:0] ring_add(
        input logic [ADDR_W-1:0] base,
        input logic [CNT_W-1:0]  offset
    );
        logic [CNT_W:0] pos;
        pos = (CNT_W+1)'(base) + (CNT_W+1)'(offset);
        if (pos >= (CNT_W+1)'(DEPTH))
        begin
            pos = pos - (CNT_W+1)'(DEPTH);
        end
        return pos[ADDR_W-1:0];
    endfunction

endpackage

>>> rtl/dqs_front.sv
// Front end: takes items on the start/busy handshake and classifies the action.
// Depends on dqs_pkg; feeds dqs_queue.
`timescale 1ns / 1ps

module dqs_front
    import dqs_pkg::*;
(
    input  logic                     start,
    output logic                     busy,
    input  logic [ACT_W-1:0]         action,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     q_ready,
    output logic                     q_write,
    output cmd_t                     q_cmd
);

    // The block is busy whenever the command queue has no room.
    assign busy    = !q_ready;
    assign q_write = start && q_ready;

    // Decode the action into an operation class and a side.
    always_comb
    begin
        q_cmd.value    = value;
        q_cmd.at_front = 1'b0;
        case (action)
            ACT_PUSH_BACK:
            begin
                q_cmd.kind = OP_PUSH;
            end
            ACT_PUSH_FRONT:
            begin
                q_cmd.kind     = OP_PUSH;
                q_cmd.at_front = 1'b1;
            end
            ACT_POP_FRONT:
            begin
                q_cmd.kind     = OP_POP;
                q_cmd.at_front = 1'b1;
            end
            ACT_POP_BACK:
            begin
                q_cmd.kind = OP_POP;
            end
            ACT_CLEAR:
            begin
                q_cmd.kind = OP_CLEAR;
            end
            default:
            begin
                // Query and the unused codes leave the state alone.
                q_cmd.kind = OP_QUERY;
            end
        endcase
    end

endmodule

>>> rtl/dqs_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on dqs_pkg for the command type.
`timescale 1ns / 1ps

module dqs_queue
    import dqs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic ready,
    input  logic rd_en,
    output logic rd_valid,
    output cmd_t rd_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign ready    = (fill_reg != 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];

    // Pointer and fill update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        fill_next   = fill_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Command storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

>>> rtl/dqs_back.sv
// Back end: carries out queued commands on the ring store, count and running sum.
// Depends on dqs_pkg; reads from dqs_queue.
`timescale 1ns / 1ps

module dqs_back
    import dqs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    input  cmd_t    q_cmd,
    output logic    q_take,
    output result_t result
);

    back_state_t               state_reg;
    back_state_t               state_next;
    logic [ADDR_W-1:0]         head_reg;
    logic [ADDR_W-1:0]         head_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic signed [DATA_W-1:0]  sum_reg;
    logic signed [DATA_W-1:0]  sum_next;
    logic                      pop_front_reg;
    logic                      pop_front_next;
    logic                      done_reg;
    logic                      done_next;
    status_t                   status_reg;
    status_t                   status_next;

    logic signed [DATA_W-1:0]  entry_mem [DEPTH];
    logic signed [DATA_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]         rd_addr;
    logic [ADDR_W-1:0]         wr_addr;
    logic                      mem_we;

    // Next state: only a pop on a non-empty store needs the read cycle.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid && (q_cmd.kind == OP_POP) && (count_reg != '0))
                begin
                    state_next = B_POP;
                end
            end
            B_POP:
            begin
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        pop_front_next = pop_front_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        q_take         = 1'b0;
        mem_we         = 1'b0;
        wr_addr        = head_reg;
        rd_addr        = head_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_take = 1'b1;
                    case (q_cmd.kind)
                        OP_PUSH:
                        begin
                            done_next = 1'b1;
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_DONE;
                                mem_we      = 1'b1;
                                if (q_cmd.at_front)
                                begin
                                    head_next = ring_add(head_reg, CNT_W'(DEPTH - 1));
                                    wr_addr   = head_next;
                                end
                                else
                                begin
                                    wr_addr = ring_add(head_reg, count_reg);
                                end
                                count_next = count_reg + CNT_W'(1);
                                sum_next   = sum_reg + q_cmd.value;
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // Fetch the leaving entry; the sum is updated next cycle.
                                pop_front_next = q_cmd.at_front;
                                if (!q_cmd.at_front)
                                begin
                                    rd_addr = ring_add(head_reg, count_reg - CNT_W'(1));
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_DONE;
                            count_next  = '0;
                            sum_next    = '0;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_DONE;
                        end
                    endcase
                end
            end
            B_POP:
            begin
                done_next   = 1'b1;
                status_next = ST_DONE;
                sum_next    = sum_reg - rd_data_reg;
                count_next  = count_reg - CNT_W'(1);
                if (pop_front_reg)
                begin
                    head_next = ring_add(head_reg, CNT_W'(1));
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            pop_front_reg <= 1'b0;
            done_reg      <= 1'b0;
            status_reg    <= ST_DONE;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            pop_front_reg <= pop_front_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
        end
    end

    // Ring store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[wr_addr] <= q_cmd.value;
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

    assign result.done   = done_reg;
    assign result.status = status_reg;
    assign result.count  = count_reg;
    assign result.sum    = sum_reg;

endmodule

>>> rtl/deque_with_count_and_sum.sv
// Top level of the bounded double-ended queue with entry count and running sum.
// Depends on dqs_pkg, dqs_front, dqs_queue and dqs_back.
`timescale 1ns / 1ps

// An item is taken at a rising edge with start high and busy low, and goes into a
// two-entry command queue; busy is high only while that queue is full. The back end
// handles a push, clear or query in its idle state; a pop of a held entry also
// passes through the pop state: the idle state reads the leaving entry from the
// ring store's registered read port, and the pop state subtracts it from the sum.
// Each result is shown on status, entry_count and total for exactly one cycle with
// done high; it must be taken then, as the block cannot hold it. Results come in
// the order the items were taken. No clearing pass follows reset.
module deque_with_count_and_sum
    import dqs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [ACT_W-1:0]          action,
    input  logic signed [DATA_W-1:0]  value,
    output logic                      done,
    output logic [STAT_W-1:0]         status,
    output logic [COUNT_W-1:0]        entry_count,
    output logic signed [DATA_W-1:0]  total
);

    logic    q_ready;
    logic    q_write;
    cmd_t    wr_cmd;
    logic    q_valid;
    logic    q_take;
    cmd_t    rd_cmd;
    result_t result;

    // Accept and classify.
    dqs_front u_front (
        .start   (start),
        .busy    (busy),
        .action  (action),
        .value   (value),
        .q_ready (q_ready),
        .q_write (q_write),
        .q_cmd   (wr_cmd)
    );

    // Decoupling queue.
    dqs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_write),
        .wr_cmd   (wr_cmd),
        .ready    (q_ready),
        .rd_en    (q_take),
        .rd_valid (q_valid),
        .rd_cmd   (rd_cmd)
    );

    // Execute on the ring store.
    dqs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (rd_cmd),
        .q_take  (q_take),
        .result  (result)
    );

    assign done        = result.done;
    assign status      = result.status;
    assign entry_count = COUNT_W'(result.count);
    assign total       = result.sum;

    // A reported status is always one of the defined codes.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_DONE || status == ST_FULL || status == ST_EMPTY))
        else $error("undefined status code reported");

    // An ignored pop only happens on an empty store.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (entry_count == '0))
        else $error("pop flagged empty while entries are held");

    // A rejected push only happens on a full store.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (entry_count == COUNT_W'(DEPTH)))
        else $error("push flagged full while room remains");

    // The command queue can only fill up through an item accepted the cycle before.
    a_no_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !$past(busy)) |-> $past(start))
        else $error("queue filled without an accepted item");

endmodule

>>> sim/deque_with_count_and_sum_tb.sv
// Self-checking testbench for the bounded double-ended queue with count and sum.
// Depends on dqs_pkg and deque_with_count_and_sum; all stimulus and checking live here.
`timescale 1ns / 1ps

module deque_with_count_and_sum_tb;
    import dqs_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEMS_PER_PHASE = 390;
    localparam int DRAIN_CYCLES = 10;
    localparam int REPORT_MAX   = 10;

    // Action codes with no name in the package.
    localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    // One result: status, count and sum after the action.
    typedef struct {
        status_t                  st;
        logic [COUNT_W-1:0]       cnt;
        logic signed [DATA_W-1:0] sum;
    } deque_result_t;

    // One row of the directed table; the typed result is used only where typed is set.
    typedef struct {
        logic [ACT_W-1:0]         act;
        logic signed [DATA_W-1:0] val;
        int                       reps;
        bit                       typed;
        deque_result_t            res;
    } stim_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [ACT_W-1:0]          action;
    logic signed [DATA_W-1:0]  value;
    logic                      done;
    logic [STAT_W-1:0]         status;
    logic [COUNT_W-1:0]        entry_count;
    logic signed [DATA_W-1:0]  total;

    // Shadow copy of the queue contents kept by the predictor.
    logic signed [DATA_W-1:0]  ring_copy [DEPTH];
    int                        head_copy;
    int                        fill_copy;
    logic signed [DATA_W-1:0]  sum_copy;

    deque_result_t             pending_results [$];
    stim_row_t                 stim_table [$];

    int  cycle_count;
    int  mismatch_count;
    int  results_checked;
    int  items_sent;
    int  full_rejects;
    int  empty_pops;
    int  peak_fill;
    int  sender_idle_pct;

    deque_with_count_and_sum dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .value       (value),
        .done        (done),
        .status      (status),
        .entry_count (entry_count),
        .total       (total)
    );

    // Free-running clock.
    always #HALF_PERIOD clk = ~clk;

    // Cycle counter for the run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Apply one action to the shadow queue and return the result it should produce.
    function automatic deque_result_t apply_deque_action(
        input logic [ACT_W-1:0]         act,
        input logic signed [DATA_W-1:0] val
    );
        deque_result_t r;
        int            slot;
        r.st = ST_DONE;
        case (act)
            ACT_PUSH_BACK, ACT_PUSH_FRONT:
            begin
                if (fill_copy >= DEPTH)
                begin
                    r.st = ST_FULL;
                    full_rejects++;
                end
                else
                begin
                    if (act == ACT_PUSH_FRONT)
                    begin
                        head_copy = (head_copy + DEPTH - 1) % DEPTH;
                        slot = head_copy;
                    end
                    else
                    begin
                        slot = (head_copy + fill_copy) % DEPTH;
                    end
                    ring_copy[slot] = val;
                    fill_copy++;
                    sum_copy = sum_copy + val;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK:
            begin
                if (fill_copy == 0)
                begin
                    r.st = ST_EMPTY;
                    empty_pops++;
                end
                else
                begin
                    if (act == ACT_POP_FRONT)
                    begin
                        slot = head_copy;
                        head_copy = (head_copy + 1) % DEPTH;
                    end
                    else
                    begin
                        slot = (head_copy + fill_copy - 1) % DEPTH;
                    end
                    sum_copy = sum_copy - ring_copy[slot];
                    fill_copy--;
                end
            end
            ACT_CLEAR:
            begin
                fill_copy = 0;
                sum_copy = '0;
            end
            default:
            begin
            end
        endcase
        if (fill_copy > peak_fill)
        begin
            peak_fill = fill_copy;
        end
        r.cnt = COUNT_W'(fill_copy);
        r.sum = sum_copy;
        return r;
    endfunction

    // Offer one item after a random idle gap and wait until the block takes it.
    // Called and returning at a falling edge.
    task automatic send_item(
        input logic [ACT_W-1:0]         act,
        input logic signed [DATA_W-1:0] val,
        input bit                       typed,
        input deque_result_t            typed_res
    );
        deque_result_t r;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start  <= 1'b1;
        action <= act;
        value  <= val;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        r = apply_deque_action(act, val);
        if (typed)
        begin
            r = typed_res;
        end
        pending_results.push_back(r);
        items_sent++;
        @(negedge clk);
    endtask

    // Compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                begin
                    $display("ERROR: result with nothing expected:",
                             " status %0d count %0d total %0d",
                             status, entry_count, total);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (status !== want.st || entry_count !== want.cnt || total !== want.sum)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                    begin
                        $display("ERROR: result %0d: expected status %0d count %0d total %0d,",
                                 results_checked, want.st, want.cnt, want.sum,
                                 " got status %0d count %0d total %0d",
                                 status, entry_count, total);
                    end
                end
            end
        end
    end

    // Run limit.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("ERROR: run limit of %0d cycles reached", CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus: directed table first, then three phases of random items.
    initial
    begin
        deque_result_t            no_res;
        stim_row_t                row;
        logic [ACT_W-1:0]         act;
        logic signed [DATA_W-1:0] val;
        bit                       filling;
        int                       pick;

        items_sent      = 0;
        full_rejects    = 0;
        empty_pops      = 0;
        peak_fill       = 0;
        sender_idle_pct = 19;
        head_copy       = 0;
        fill_copy       = 0;
        sum_copy        = '0;
        foreach (ring_copy[i])
        begin
            ring_copy[i] = '0;
        end
        no_res = '{ST_DONE, '0, '0};
        rst_n  = 1'b0;
        start  = 1'b0;
        action = ACT_QUERY;
        value  = '0;

        // Empty pops and query after reset, sum wrap at both extremes, spare codes,
        // clear when empty, a full store rejecting pushes at both ends.
        stim_table.push_back('{ACT_POP_FRONT,  0,          1, 1, '{ST_EMPTY, 0, 0}});
        stim_table.push_back('{ACT_POP_BACK,   0,          1, 1, '{ST_EMPTY, 0, 0}});
        stim_table.push_back('{ACT_QUERY,      0,          1, 1, '{ST_DONE, 0, 0}});
        stim_table.push_back('{ACT_PUSH_BACK,  VAL_MAX,    1, 1, '{ST_DONE, 1, VAL_MAX}});
        stim_table.push_back('{ACT_PUSH_FRONT, 1,          1, 1, '{ST_DONE, 2, VAL_MIN}});
        stim_table.push_back('{ACT_PUSH_BACK,  VAL_MIN,    1, 1, '{ST_DONE, 3, 0}});
        stim_table.push_back('{ACT_SPARE6,     -1,         1, 1, '{ST_DONE, 3, 0}});
        stim_table.push_back('{ACT_SPARE7,     VAL_MAX,    1, 1, '{ST_DONE, 3, 0}});
        stim_table.push_back('{ACT_POP_FRONT,  0,          1, 1, '{ST_DONE, 2, -1}});
        stim_table.push_back('{ACT_POP_BACK,   0,          1, 1, '{ST_DONE, 1, VAL_MAX}});
        stim_table.push_back('{ACT_POP_FRONT,  0,          1, 1, '{ST_DONE, 0, 0}});
        stim_table.push_back('{ACT_PUSH_FRONT, -1,         1, 1, '{ST_DONE, 1, -1}});
        stim_table.push_back('{ACT_CLEAR,      0,          1, 1, '{ST_DONE, 0, 0}});
        stim_table.push_back('{ACT_CLEAR,      0,          1, 1, '{ST_DONE, 0, 0}});
        stim_table.push_back('{ACT_PUSH_BACK,  32'sh5555_5555, 1, 0, no_res});
        stim_table.push_back('{ACT_PUSH_FRONT, 32'shAAAA_AAAA, 1, 1, '{ST_DONE, 2, -1}});
        stim_table.push_back('{ACT_CLEAR,      0,          1, 1, '{ST_DONE, 0, 0}});
        stim_table.push_back('{ACT_PUSH_BACK,  1,      DEPTH, 0, no_res});
        stim_table.push_back('{ACT_PUSH_BACK,  5,          1, 1, '{ST_FULL, 64, 64}});
        stim_table.push_back('{ACT_PUSH_FRONT, -5,         1, 1, '{ST_FULL, 64, 64}});
        stim_table.push_back('{ACT_POP_BACK,   0,          1, 1, '{ST_DONE, 63, 63}});
        stim_table.push_back('{ACT_PUSH_FRONT, VAL_MIN,    1, 1,
                               '{ST_DONE, 64, 32'sh8000_003F}});
        stim_table.push_back('{ACT_CLEAR,      0,          1, 1, '{ST_DONE, 0, 0}});
        stim_table.push_back('{ACT_QUERY,      0,          1, 1, '{ST_DONE, 0, 0}});

        // Reset, then release at a falling edge.
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table.
        foreach (stim_table[i])
        begin
            row = stim_table[i];
            for (int r = 0; r < row.reps; r++)
            begin
                send_item(row.act, row.val, row.typed, row.res);
            end
        end

        // Random items: long runs of pushes or pops so the queue swings
        // between empty and full, with some clears, queries and spare codes.
        filling = 1'b1;
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 69 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ((fill_copy == DEPTH && filling && $urandom_range(7) == 0) ||
                    (fill_copy == 0 && !filling && $urandom_range(7) == 0) ||
                    $urandom_range(199) == 0)
                begin
                    filling = !filling;
                end
                pick = $urandom_range(99);
                if (pick < 1)
                begin
                    act = ACT_CLEAR;
                end
                else if (pick < 7)
                begin
                    case ($urandom_range(2))
                        0: act = ACT_QUERY;
                        1: act = ACT_SPARE6;
                        default: act = ACT_SPARE7;
                    endcase
                end
                else if ($urandom_range(99) < (filling ? 80 : 20))
                begin
                    act = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
                end
                else
                begin
                    act = $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
                end
                case ($urandom_range(3))
                    0:
                    begin
                        case ($urandom_range(3))
                            0: val = VAL_MAX;
                            1: val = VAL_MIN;
                            2: val = '0;
                            default: val = -1;
                        endcase
                    end
                    1: val = $signed($urandom_range(200)) - 100;
                    default: val = $urandom;
                endcase
                send_item(act, val, 1'b0, no_res);
            end
        end
        start <= 1'b0;

        // Drain the outstanding results, then wait with no stimulus before reporting.
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d items and %0d checked results in %0d cycles.",
                 items_sent, results_checked, cycle_count);
        $display("Full-store rejects %0d, empty-store pops %0d, peak fill %0d, mismatches %0d.",
                 full_rejects, empty_pops, peak_fill, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> deque_with_count_and_sum.f
rtl/dqs_pkg.sv
rtl/dqs_front.sv
rtl/dqs_queue.sv
rtl/dqs_back.sv
rtl/deque_with_count_and_sum.sv
sim/deque_with_count_and_sum_tb.sv
